>>> rtl/sarac_pkg.sv
package sarac_pkg;

	localparam int REG_COUNT      = 12;
	localparam int MAX_DATA_BYTES = 3;

	localparam int IDX_W   = 4;
	localparam int DATA_W  = 24;
	localparam int CNT_W   = 6;
	localparam int CMD_W   = 8;

	// input op codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BUSY      = 2'd1,
		ST_IDLE_TICK = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	// register address table
	function automatic logic [7:0] reg_addr(input logic [IDX_W-1:0] idx);
		logic [7:0] a;
		case (idx)
			4'd0:    a = 8'h00;
			4'd1:    a = 8'h03;
			4'd2:    a = 8'h06;
			4'd3:    a = 8'h07;
			4'd4:    a = 8'h09;
			4'd5:    a = 8'h0A;
			4'd6:    a = 8'h0C;
			4'd7:    a = 8'h0E;
			4'd8:    a = 8'h11;
			4'd9:    a = 8'h14;
			4'd10:   a = 8'h17;
			4'd11:   a = 8'h1A;
			default: a = 8'h00;
		endcase
		return a;
	endfunction

	// register size in bits
	function automatic logic [5:0] reg_bits(input logic [IDX_W-1:0] idx);
		logic [5:0] b;
		case (idx)
			4'd0, 4'd1, 4'd7, 4'd8, 4'd9, 4'd10: b = 6'd24;
			4'd3, 4'd5, 4'd6:                    b = 6'd16;
			4'd2, 4'd4, 4'd11:                   b = 6'd8;
			default:                             b = 6'd0;
		endcase
		return b;
	endfunction

	// data byte count, limited to the supported maximum
	function automatic logic [2:0] reg_bytes(input logic [IDX_W-1:0] idx);
		logic [5:0] b;
		logic [2:0] n;
		b = reg_bits(idx);
		n = b[5:3];
		if (n > 3'(MAX_DATA_BYTES))
			n = 3'(MAX_DATA_BYTES);
		return n;
	endfunction

	function automatic logic [DATA_W-1:0] byte_mask(input logic [2:0] n);
		logic [DATA_W-1:0] m;
		case (n)
			3'd0:    m = 24'h000000;
			3'd1:    m = 24'h0000FF;
			3'd2:    m = 24'h00FFFF;
			default: m = 24'hFFFFFF;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/spi_adc_register_access.sv
// results are offered the cycle after acceptance; throughput: one item per
//   cycle unless out_stall holds a full result register; the access state and
//   result register update on acceptance, so a tick may follow a start at once
// reset: arst_n low clears the access state and empties the result register;
//   the result payload has no reset and is loaded by each accepted transfer
module spi_adc_register_access (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic        is_write,
	input  logic [3:0]  reg_index,
	input  logic [23:0] write_data,
	input  logic        miso,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        cs_n,
	output logic        mosi,
	output logic        sclk_pulse,
	output logic        busy_res,
	output logic        done_res,
	output logic [23:0] read_data,
	output logic [1:0]  status
);

	// access state
	logic                           active_q;
	logic [sarac_pkg::CMD_W-1:0]    cmd_q;       // command byte, sent first
	logic [sarac_pkg::DATA_W-1:0]   wdata_q;     // masked write data
	logic [sarac_pkg::CNT_W-1:0]    bits_sent_q;
	logic [sarac_pkg::CNT_W-1:0]    bits_total_q;
	logic [sarac_pkg::DATA_W-1:0]   accum_q;
	logic                           write_mode_q;

	// result register
	logic                           out_valid_q;
	logic                           cs_n_q;
	logic                           mosi_q;
	logic                           pulse_q;
	logic                           busy_q;
	logic                           done_q;
	logic [sarac_pkg::DATA_W-1:0]   rdata_q;
	sarac_pkg::status_t             status_q;

	logic in_xfer;

	// the result register is free when empty or being drained this cycle
	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	// start decode
	logic                           bad_index;
	logic [2:0]                     nbytes;
	logic [7:0]                     start_addr;
	logic [sarac_pkg::CMD_W-1:0]    start_cmd;

	assign bad_index  = ({1'b0, reg_index} >= 5'(sarac_pkg::REG_COUNT));
	assign nbytes     = sarac_pkg::reg_bytes(reg_index);
	assign start_addr = sarac_pkg::reg_addr(reg_index);
	// address in bits 7..1, read flag in bit 0
	assign start_cmd  = (start_addr << 1) | {7'd0, !is_write};

	// serial bit selection: command MSB-first, then data (writes) or zeros
	logic [sarac_pkg::CNT_W-1:0]    data_pos;
	logic                           tx_bit;
	logic [sarac_pkg::CNT_W-1:0]    sent_next;
	logic [sarac_pkg::DATA_W-1:0]   accum_next;
	logic                           in_data;

	assign in_data   = (bits_sent_q >= 6'd8);
	assign data_pos  = bits_total_q - 6'd1 - bits_sent_q;
	assign sent_next = bits_sent_q + 6'd1;

	always_comb begin
		if (!in_data) begin
			tx_bit = cmd_q[3'd7 - bits_sent_q[2:0]];
		end else if (!write_mode_q) begin
			tx_bit = 1'b0;
		end else if (data_pos >= 6'(sarac_pkg::DATA_W)) begin
			tx_bit = 1'b0;
		end else begin
			tx_bit = wdata_q[data_pos[4:0]];
		end
	end

	// read bits are shifted in only after the command byte
	assign accum_next = (in_data && !write_mode_q) ?
		{accum_q[sarac_pkg::DATA_W-2:0], miso} : accum_q;

	// access state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			cmd_q        <= '0;
			wdata_q      <= '0;
			bits_sent_q  <= '0;
			bits_total_q <= '0;
			accum_q      <= '0;
			write_mode_q <= 1'b0;
		end else if (in_xfer) begin
			if (op == sarac_pkg::OP_START) begin
				if (!active_q && !bad_index) begin
					active_q     <= 1'b1;
					cmd_q        <= start_cmd;
					wdata_q      <= is_write ?
						(write_data & sarac_pkg::byte_mask(nbytes)) : '0;
					bits_sent_q  <= '0;
					bits_total_q <= 6'd8 + {nbytes, 3'b000};
					accum_q      <= '0;
					write_mode_q <= is_write;
				end
			end else if (active_q) begin
				bits_sent_q <= sent_next;
				accum_q     <= accum_next;
				if (sent_next >= bits_total_q)
					active_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// next result payload
	logic                           cs_n_d;
	logic                           mosi_d;
	logic                           pulse_d;
	logic                           busy_d;
	logic                           done_d;
	logic [sarac_pkg::DATA_W-1:0]   rdata_d;
	sarac_pkg::status_t             status_d;

	always_comb begin
		mosi_d   = 1'b0;
		pulse_d  = 1'b0;
		done_d   = 1'b0;
		rdata_d  = '0;
		status_d = sarac_pkg::ST_OK;
		cs_n_d   = !active_q;
		busy_d   = active_q;
		if (op == sarac_pkg::OP_START) begin
			if (active_q) begin
				status_d = sarac_pkg::ST_BUSY;
			end else if (bad_index) begin
				status_d = sarac_pkg::ST_BAD_INDEX;
			end else begin
				cs_n_d = 1'b0;
				busy_d = 1'b1;
			end
		end else if (!active_q) begin
			status_d = sarac_pkg::ST_IDLE_TICK;
		end else begin
			mosi_d  = tx_bit;
			pulse_d = 1'b1;
			if (sent_next >= bits_total_q) begin
				// last bit clocked: release chip select
				cs_n_d = 1'b1;
				busy_d = 1'b0;
				done_d = 1'b1;
				if (!write_mode_q)
					rdata_d = accum_next;
			end
		end
	end

	// payload of the result transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cs_n_q   <= cs_n_d;
			mosi_q   <= mosi_d;
			pulse_q  <= pulse_d;
			busy_q   <= busy_d;
			done_q   <= done_d;
			rdata_q  <= rdata_d;
			status_q <= status_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign cs_n       = cs_n_q;
	assign mosi       = mosi_q;
	assign sclk_pulse = pulse_q;
	assign busy_res   = busy_q;
	assign done_res   = done_q;
	assign read_data  = rdata_q;
	assign status     = status_q;

`ifndef SYNTHESIS
	// chip select and busy are always complements on a result
	a_cs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cs_n != busy_res))
		else $error("cs_n and busy_res disagree");

	// finishing an access needs a clock pulse and leaves the block idle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> (sclk_pulse && !busy_res))
		else $error("done without pulse or still busy");

	// a clock pulse only on a successful tick
	a_pulse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sclk_pulse) |-> (status == sarac_pkg::ST_OK))
		else $error("pulse with error status");

	// access state moves only on an accepted input
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer |=> ($stable(active_q) && $stable(bits_sent_q)))
		else $error("access state changed without a transfer");

	// the result reflects the access state it left behind
	a_busy_track: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (busy_res == active_q))
		else $error("busy_res does not match access state");
`endif

endmodule
